FILE: src/udhms_pkg.sv
// Types, constants and helper functions shared by the stopwatch core.
// No dependencies; every other file in src imports this package.
package udhms_pkg;

    localparam logic [6:0] HOURS_MAX   = 7'd99;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [5:0] SECONDS_MAX = 6'd59;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Item kinds carried on s_tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Preset values carried by a load item
    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       run;
    } load_t;

    // Time and run flag of the channel
    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       run;
    } hms_t;

    // Tens digit of a value below 100: (v * 205) >> 11
    function automatic logic [3:0] tens_digit(input logic [6:0] v);
        logic [14:0] prod;
        begin
            prod = 15'(v) * 15'd205;
            tens_digit = prod[14:11];
        end
    endfunction

    // Active-low segment code, bit 0 is segment a, bit 7 the decimal point (off)
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] lit;
        begin
            case (d)
                4'd0:    lit = 8'h3f;
                4'd1:    lit = 8'h06;
                4'd2:    lit = 8'h5b;
                4'd3:    lit = 8'h4f;
                4'd4:    lit = 8'h66;
                4'd5:    lit = 8'h6d;
                4'd6:    lit = 8'h7d;
                4'd7:    lit = 8'h07;
                4'd8:    lit = 8'h7f;
                4'd9:    lit = 8'h6f;
                default: lit = 8'h00;
            endcase
            seg_code = ~lit;
        end
    endfunction

endpackage

FILE: src/udhms_counter.sv
// Time and run-flag state of the stopwatch with its next-value logic.
// Depends on udhms_pkg for the load and time structs and the limits.
module udhms_counter
    import udhms_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  logic  func,
    input  load_t load,
    input  logic  count_down,
    output hms_t  next_time
);

    hms_t state_reg;

    // Work out the time after this item
    always_comb begin
        next_time = state_reg;
        if (func == FUNC_LOAD) begin
            next_time.hours   = (load.hours   > HOURS_MAX)   ? HOURS_MAX   : load.hours;
            next_time.minutes = (load.minutes > MINUTES_MAX) ? MINUTES_MAX : load.minutes;
            next_time.seconds = (load.seconds > SECONDS_MAX) ? SECONDS_MAX : load.seconds;
            next_time.run     = load.run;
        end else if (state_reg.run) begin
            if (count_down) begin
                // Count down, stop at zero on underflow
                if (state_reg.seconds != 6'd0) begin
                    next_time.seconds = state_reg.seconds - 6'd1;
                end else if (state_reg.minutes != 6'd0) begin
                    next_time.seconds = SECONDS_MAX;
                    next_time.minutes = state_reg.minutes - 6'd1;
                end else if (state_reg.hours != 7'd0) begin
                    next_time.seconds = SECONDS_MAX;
                    next_time.minutes = MINUTES_MAX;
                    next_time.hours   = state_reg.hours - 7'd1;
                end else begin
                    next_time.run = 1'b0;
                end
            end else begin
                // Count up, hold at the top value on overflow
                if (state_reg.seconds < SECONDS_MAX) begin
                    next_time.seconds = state_reg.seconds + 6'd1;
                end else if (state_reg.minutes < MINUTES_MAX) begin
                    next_time.seconds = 6'd0;
                    next_time.minutes = state_reg.minutes + 6'd1;
                end else if (state_reg.hours < HOURS_MAX) begin
                    next_time.seconds = 6'd0;
                    next_time.minutes = 6'd0;
                    next_time.hours   = state_reg.hours + 7'd1;
                end else begin
                    next_time.hours   = HOURS_MAX;
                    next_time.minutes = MINUTES_MAX;
                    next_time.seconds = SECONDS_MAX;
                    next_time.run     = 1'b0;
                end
            end
        end
    end

    // Commit the new time when an item passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= next_time;
        end
    end

endmodule

FILE: src/udhms_seg_enc.sv
// Two-digit seven-segment encoder for a value below 100.
// Depends on udhms_pkg for the digit split and the segment table.
module udhms_seg_enc
    import udhms_pkg::*;
(
    input  logic [6:0] value,
    output logic [7:0] seg_ones,
    output logic [7:0] seg_tens
);

    logic [3:0] tens;
    logic [6:0] tens_x10;
    logic [6:0] ones_full;

    // Split into digits and look up both codes
    always_comb begin
        tens      = tens_digit(value);
        tens_x10  = 7'({3'd0, tens} * 7'd10);
        ones_full = value - tens_x10;
        seg_ones  = seg_code(ones_full[3:0]);
        seg_tens  = seg_code(tens);
    end

endmodule

FILE: src/up_down_hms_timer_seven_segment_core.sv
// Up/down hours:minutes:seconds stopwatch with seven-segment digit codes.
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless m_tready stalls; a single stage does the time update.
// Reset (aresetn low, synchronous) clears the time to 00:00:00, stops the count,
// selects counting up and empties both pipeline registers.
module up_down_hms_timer_seven_segment_core
    import udhms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: count_down
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_hours[6:0], load_minutes[12:7], load_seconds[18:13], load_run[19], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  logic                  s_tuser,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hours[6:0], minutes[12:7], seconds[18:13], running[19], seg_min_ones[27:20],
    // seg_min_tens[35:28], seg_hour_ones[43:36], seg_hour_tens[51:44], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic       count_down_reg;
    logic       in_valid_reg;
    logic       in_func_reg;
    load_t      in_load_reg;
    logic       out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic       out_advance;
    logic       in_advance;
    hms_t       next_time;
    logic [7:0] seg_min_ones;
    logic [7:0] seg_min_tens;
    logic [7:0] seg_hour_ones;
    logic [7:0] seg_hour_tens;

    // Hold the count direction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_down_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            count_down_reg <= cfg_wr_data;
        end
    end

    // Pipeline handshake
    assign out_advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_tvalid) begin
            in_func_reg         <= s_tuser;
            in_load_reg.hours   <= s_tdata[6:0];
            in_load_reg.minutes <= s_tdata[12:7];
            in_load_reg.seconds <= s_tdata[18:13];
            in_load_reg.run     <= s_tdata[19];
        end
    end

    // Time update
    udhms_counter u_counter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (out_advance),
        .func       (in_func_reg),
        .load       (in_load_reg),
        .count_down (count_down_reg),
        .next_time  (next_time)
    );

    // Digit codes for minutes and hours
    udhms_seg_enc u_seg_min (
        .value    ({1'b0, next_time.minutes}),
        .seg_ones (seg_min_ones),
        .seg_tens (seg_min_tens)
    );

    udhms_seg_enc u_seg_hour (
        .value    (next_time.hours),
        .seg_ones (seg_hour_ones),
        .seg_tens (seg_hour_tens)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance) begin
            out_data_reg <= {4'd0, seg_hour_tens, seg_hour_ones, seg_min_tens, seg_min_ones,
                             next_time.run, next_time.seconds, next_time.minutes,
                             next_time.hours};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/up_down_hms_timer_seven_segment_core_tb.sv
// Self-checking bench for up_down_hms_timer_seven_segment_core: stream driver,
// stream monitor and a cycle-free stopwatch predictor, all in this module.
// Depends on udhms_pkg and the core under src.
`timescale 1ns / 100ps

module up_down_hms_timer_seven_segment_core_tb;
    import udhms_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    // Active-high segment patterns for digits 9 down to 0, digit 0 in the low byte
    localparam logic [79:0] DIGIT_LIT = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                         8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

    // One queued input item
    typedef struct packed {
        logic  func;
        load_t ld;
    } stim_t;

    // Expected display after one item
    typedef struct packed {
        hms_t       clock;
        logic [7:0] min_ones;
        logic [7:0] min_tens;
        logic [7:0] hour_ones;
        logic [7:0] hour_tens;
    } display_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    stim_t    queued_items[$];
    display_t expected_displays[$];

    // Predictor state
    hms_t sw_time = '0;
    logic count_down_q;

    logic gaps_enabled;
    int   send_gap;
    int   recv_gap;
    int   hold_cnt;
    int   hold_requests;
    int   holds_done;
    int   idle_cycles;
    int   errors       = 0;
    int   n_results    = 0;
    int   n_loads      = 0;
    int   n_ticks      = 0;
    int   n_top_stops  = 0;
    int   n_zero_stops = 0;

    up_down_hms_timer_seven_segment_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Active-low code of one decimal digit, decimal point off
    function automatic logic [7:0] seg_of(input int digit);
        return ~DIGIT_LIT[digit*8 +: 8];
    endfunction

    // Apply one item to the stopwatch copy and return the display it leaves
    function automatic display_t advance_stopwatch(input logic func, input load_t ld);
        display_t d;
        if (func == FUNC_LOAD) begin
            n_loads++;
            sw_time.hours   = (ld.hours > HOURS_MAX) ? HOURS_MAX : ld.hours;
            sw_time.minutes = (ld.minutes > MINUTES_MAX) ? MINUTES_MAX : ld.minutes;
            sw_time.seconds = (ld.seconds > SECONDS_MAX) ? SECONDS_MAX : ld.seconds;
            sw_time.run     = ld.run;
        end else begin
            n_ticks++;
            if (sw_time.run && !count_down_q) begin
                // count up, hold and stop past the top
                if (sw_time.seconds < SECONDS_MAX) begin
                    sw_time.seconds = sw_time.seconds + 6'd1;
                end else if (sw_time.minutes < MINUTES_MAX) begin
                    sw_time.seconds = 6'd0;
                    sw_time.minutes = sw_time.minutes + 6'd1;
                end else if (sw_time.hours < HOURS_MAX) begin
                    sw_time.seconds = 6'd0;
                    sw_time.minutes = 6'd0;
                    sw_time.hours   = sw_time.hours + 7'd1;
                end else begin
                    sw_time.run = 1'b0;
                    n_top_stops++;
                end
            end else if (sw_time.run) begin
                // count down, hold and stop below zero
                if (sw_time.seconds > 0) begin
                    sw_time.seconds = sw_time.seconds - 6'd1;
                end else if (sw_time.minutes > 0) begin
                    sw_time.seconds = SECONDS_MAX;
                    sw_time.minutes = sw_time.minutes - 6'd1;
                end else if (sw_time.hours > 0) begin
                    sw_time.seconds = SECONDS_MAX;
                    sw_time.minutes = MINUTES_MAX;
                    sw_time.hours   = sw_time.hours - 7'd1;
                end else begin
                    sw_time.run = 1'b0;
                    n_zero_stops++;
                end
            end
        end
        d.clock     = sw_time;
        d.min_ones  = seg_of(sw_time.minutes % 10);
        d.min_tens  = seg_of(sw_time.minutes / 10);
        d.hour_ones = seg_of(sw_time.hours % 10);
        d.hour_tens = seg_of(sw_time.hours / 10);
        return d;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d (0x%0h), expected %0d (0x%0h)",
                 $time, field, got, got, want, want);
        errors++;
    endtask

    function automatic int draw_gap();
        return gaps_enabled ? int'($urandom_range(0, 17)) : 0;
    endfunction

    // Sender: present queued items, waiting a drawn number of cycles between them
    always @(posedge aclk) begin : drive_items
        load_t ld;
        stim_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= FUNC_TICK;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                ld.hours   = s_tdata[6:0];
                ld.minutes = s_tdata[12:7];
                ld.seconds = s_tdata[18:13];
                ld.run     = s_tdata[19];
                expected_displays.push_back(advance_stopwatch(s_tuser, ld));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (queued_items.size() > 0) begin
                    nxt = queued_items.pop_front();
                    s_tuser  <= nxt.func;
                    s_tdata  <= {4'b0, nxt.ld.run, nxt.ld.seconds, nxt.ld.minutes,
                                 nxt.ld.hours};
                    s_tvalid <= 1'b1;
                    send_gap <= draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result, then stall for a drawn gap or a long hold
    always @(posedge aclk) begin : collect_results
        display_t want;
        int wait_n;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_gap   <= 0;
            hold_cnt   <= 0;
            holds_done <= 0;
        end else begin
            wait_n = recv_gap;
            if (m_tvalid && m_tready) begin
                wait_n = draw_gap();
                n_results++;
                if (expected_displays.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(m_tdata[31:0]), 0);
                end else begin
                    want = expected_displays.pop_front();
                    if (m_tdata[6:0] != want.clock.hours)
                        report_mismatch("hours", int'(m_tdata[6:0]),
                                        int'(want.clock.hours));
                    if (m_tdata[12:7] != want.clock.minutes)
                        report_mismatch("minutes", int'(m_tdata[12:7]),
                                        int'(want.clock.minutes));
                    if (m_tdata[18:13] != want.clock.seconds)
                        report_mismatch("seconds", int'(m_tdata[18:13]),
                                        int'(want.clock.seconds));
                    if (m_tdata[19] != want.clock.run)
                        report_mismatch("running", int'(m_tdata[19]),
                                        int'(want.clock.run));
                    if (m_tdata[27:20] != want.min_ones)
                        report_mismatch("seg_min_ones", int'(m_tdata[27:20]),
                                        int'(want.min_ones));
                    if (m_tdata[35:28] != want.min_tens)
                        report_mismatch("seg_min_tens", int'(m_tdata[35:28]),
                                        int'(want.min_tens));
                    if (m_tdata[43:36] != want.hour_ones)
                        report_mismatch("seg_hour_ones", int'(m_tdata[43:36]),
                                        int'(want.hour_ones));
                    if (m_tdata[51:44] != want.hour_tens)
                        report_mismatch("seg_hour_tens", int'(m_tdata[51:44]),
                                        int'(want.hour_tens));
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                recv_gap <= wait_n;
                m_tready <= 1'b0;
            end else if (hold_requests != holds_done) begin
                holds_done <= holds_done + 1;
                hold_cnt   <= HOLD_CYCLES;
                recv_gap   <= wait_n;
                m_tready   <= 1'b0;
            end else if (wait_n > 0) begin
                recv_gap <= wait_n - 1;
                m_tready <= 1'b0;
            end else begin
                recv_gap <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Abort when neither side has moved an item for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timed out after %0d cycles without progress", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic func, input int h, input int m, input int s,
                              input logic run);
        stim_t it;
        it.func       = func;
        it.ld.hours   = h[6:0];
        it.ld.minutes = m[5:0];
        it.ld.seconds = s[5:0];
        it.ld.run     = run;
        queued_items.push_back(it);
    endtask

    // Tick with random junk in the load fields
    task automatic queue_tick();
        queue_item(FUNC_TICK, $urandom_range(0, 127), $urandom_range(0, 63),
                   $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    // Field value biased to the edges, sometimes beyond the clamp
    function automatic int pick_field(input int top, input int raw_top);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            2:       return top - 1;
            3:       return $urandom_range(top + 1, raw_top);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // Hold until every queued item has gone and every result has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (queued_items.size() != 0 || s_tvalid || expected_displays.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_direction(input logic down);
        wait_drained();
        repeat (2) @(negedge aclk);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= down;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        count_down_q = down;
        @(negedge aclk);
    endtask

    // Mostly presets followed by runs of ticks, with stray loads and ticks between
    task automatic random_phase(input int n_items);
        int added;
        int kind;
        int ticks;
        int h;
        int m;
        int s;
        added = 0;
        while (added < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    // start close to the limit of the current direction
                    if (count_down_q) begin
                        h = 0;
                        m = $urandom_range(0, 1);
                        s = $urandom_range(0, 10);
                    end else begin
                        h = 99;
                        m = $urandom_range(58, 59);
                        s = $urandom_range(45, 59);
                    end
                end else begin
                    h = pick_field(99, 127);
                    m = pick_field(59, 63);
                    s = pick_field(59, 63);
                end
                queue_item(FUNC_LOAD, h, m, s, $urandom_range(0, 7) != 0);
                ticks = $urandom_range(1, 30);
                repeat (ticks) queue_tick();
                added += ticks + 1;
            end else if (kind < 9) begin
                queue_item(FUNC_LOAD, $urandom_range(0, 127), $urandom_range(0, 63),
                           $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                added++;
            end else begin
                queue_tick();
                added++;
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        count_down_q  = 1'b0;
        gaps_enabled  = 1'b1;
        hold_requests = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Up count: stopped tick, top stop, clamp, carries, ignored tick fields
        write_direction(1'b0);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 99, 59, 58, 1'b1);
        repeat (3) queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 127, 63, 63, 1'b1);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 0, 59, 59, 1'b1);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 9, 59, 59, 1'b1);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 0, 0, 0, 1'b0);
        queue_item(FUNC_TICK, 127, 63, 63, 1'b1);

        // Down count: zero stop, borrows, clamp while stopped
        write_direction(1'b1);
        queue_item(FUNC_LOAD, 0, 0, 1, 1'b1);
        repeat (3) queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 1, 0, 0, 1'b1);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 10, 0, 0, 1'b1);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);
        queue_item(FUNC_LOAD, 100, 60, 60, 1'b0);
        queue_item(FUNC_TICK, 0, 0, 0, 1'b0);

        // Random phases, alternating direction; some without gaps, two with a long stall
        for (int p = 0; p < 11; p++) begin
            write_direction(p[0]);
            gaps_enabled = (p % 4) != 2;
            random_phase(165);
            if (p == 3 || p == 8)
                hold_requests++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Ran %0d loads and %0d ticks in both directions; %0d top and %0d zero stops",
                 n_loads, n_ticks, n_top_stops, n_zero_stops);
        $display("Compared %0d results, %0d mismatching fields", n_results, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
